FILE: sv/aml_s5_pkg.sv
// shared types and constants of the s5 sleep type extractor
// request payloads, parse phase encoding, aml opcode values; no dependencies
package aml_s5_pkg;

	localparam int unsigned WIN_DEPTH = 6;

	localparam logic [7:0] NAME_OP    = 8'h08;
	localparam logic [7:0] PACKAGE_OP = 8'h12;
	localparam logic [7:0] ROOT_CHAR  = 8'h5C;
	localparam logic [7:0] UNDER_CHAR = 8'h5F;
	localparam logic [7:0] S_CHAR     = 8'h53;
	localparam logic [7:0] FIVE_CHAR  = 8'h35;

	localparam logic [7:0] ZERO_OP  = 8'h00;
	localparam logic [7:0] ONE_OP   = 8'h01;
	localparam logic [7:0] ONES_OP  = 8'hFF;
	localparam logic [7:0] BYTE_OP  = 8'h0A;
	localparam logic [7:0] WORD_OP  = 8'h0B;
	localparam logic [7:0] DWORD_OP = 8'h0C;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} aml_s5_in_t;

	typedef struct packed {
		logic        found;
		logic [15:0] sleep_type_a;
		logic [15:0] sleep_type_b;
	} aml_s5_out_t;

	// one byte handed from the input stage to the window and the parser
	typedef struct packed {
		logic       step;
		logic [7:0] data;
		logic       last;
	} aml_s5_step_t;

	typedef enum logic [6:0] {
		PH_SCAN     = 7'b0000001,
		PH_LEAD     = 7'b0000010,
		PH_SKIP     = 7'b0000100,
		PH_COUNT    = 7'b0001000,
		PH_INT_OP   = 7'b0010000,
		PH_INT_DATA = 7'b0100000,
		PH_DONE     = 7'b1000000
	} aml_s5_phase_t;

endpackage

FILE: sv/aml_s5_sleep_type_extractor.sv
// top level of the s5 sleep type extractor: input stage, window, parser, result register
// depends on aml_s5_pkg, aml_s5_window, aml_s5_parser

// One byte of a definition block body is taken per cycle on the item channel,
// with is_last marking the final byte of a table. Each request lands in an input
// register; from there the window and parser update in a single shallow step,
// so throughput is one byte per clock while no last byte is held back; the result
// register loads as that byte moves on. Exactly one result request leaves
// per table, produced by the byte marked last; it carries found and the first
// two integers of the \_S5_ package (zero where absent). Only a last byte whose
// result finds the result register still full waits, and then only until that
// register is taken. After the last byte all parse state returns to reset, so
// the next byte starts a fresh table.
module aml_s5_sleep_type_extractor (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  aml_s5_pkg::aml_s5_in_t  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output aml_s5_pkg::aml_s5_out_t result
);
	import aml_s5_pkg::*;

	aml_s5_in_t   item_s1;
	logic         valid_s1;
	aml_s5_out_t  result_q;
	logic         result_valid_q;
	logic         advance;
	logic         name_hit;
	aml_s5_step_t stp;
	aml_s5_out_t  res_next;

	// a non-last byte always moves on; a last byte needs room in the result register
	assign advance    = valid_s1 && (!item_s1.is_last || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	assign stp.step = advance;
	assign stp.data = item_s1.data_byte;
	assign stp.last = item_s1.is_last;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) item_s1 <= item;
	end

	aml_s5_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.stp      (stp),
		.name_hit (name_hit)
	);

	aml_s5_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.stp      (stp),
		.name_hit (name_hit),
		.res      (res_next)
	);

	// result register, loaded by the last byte of a table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.is_last) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.is_last) result_q <= res_next;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a new result only follows a last byte leaving the input stage
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(valid_s1 && item_s1.is_last))
		else $error("result appeared without a last byte");

	// no package count read means no integers either
	a_absent_values_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.found |->
			result_q.sleep_type_a == 16'h0000 && result_q.sleep_type_b == 16'h0000)
		else $error("values without a found package");

	// a byte held back by a full result register stays in the input stage
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled byte lost from input stage");

endmodule

FILE: sv/aml_s5_window.sv
// six byte history window spotting a name op, optionally rooted, then _S5_
// depends on aml_s5_pkg
module aml_s5_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aml_s5_pkg::aml_s5_step_t stp,
	output logic                  name_hit
);
	import aml_s5_pkg::*;

	logic [7:0] recent_q [WIN_DEPTH];
	logic [2:0] hist_q;
	logic       name_seen;
	logic       plain_seen;
	logic       rooted_seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) recent_q[i] <= 8'h00;
			hist_q <= 3'd0;
		end else if (stp.step) begin
			if (stp.last) begin
				for (int i = 0; i < WIN_DEPTH; i++) recent_q[i] <= 8'h00;
				hist_q <= 3'd0;
			end else begin
				for (int i = WIN_DEPTH - 1; i > 0; i--) recent_q[i] <= recent_q[i - 1];
				recent_q[0] <= stp.data;
				if (hist_q < 3'(WIN_DEPTH)) hist_q <= hist_q + 3'd1;
			end
		end
	end

	always_comb begin
		name_seen   = recent_q[3] == UNDER_CHAR && recent_q[2] == S_CHAR &&
		              recent_q[1] == FIVE_CHAR && recent_q[0] == UNDER_CHAR &&
		              hist_q >= 3'd4;
		plain_seen  = hist_q >= 3'd5 && recent_q[4] == NAME_OP;
		rooted_seen = hist_q >= 3'd6 && recent_q[5] == NAME_OP && recent_q[4] == ROOT_CHAR;
		name_hit    = name_seen && (plain_seen || rooted_seen);
	end

endmodule

FILE: sv/aml_s5_parser.sv
// package parse state: length skip, element count and two aml integers
// depends on aml_s5_pkg; returns the result as it stands after the current byte
module aml_s5_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  aml_s5_pkg::aml_s5_step_t stp,
	input  logic                    name_hit,
	output aml_s5_pkg::aml_s5_out_t  res
);
	import aml_s5_pkg::*;

	aml_s5_phase_t phase_q, n_phase;
	logic [1:0]  skip_q, n_skip;
	logic [7:0]  count_q, n_count;
	logic        idx_q, n_idx;
	logic [2:0]  left_q, n_left;
	logic [2:0]  width_q, n_width;
	logic [15:0] acc_q, n_acc;
	logic [15:0] a_q, n_a;
	logic [15:0] b_q, n_b;
	logic        found_q, n_found;
	logic        fin;
	logic [15:0] fin_val;
	logic [2:0]  pos;
	logic [2:0]  op_width;

	always_comb begin
		n_phase  = phase_q;
		n_skip   = skip_q;
		n_count  = count_q;
		n_idx    = idx_q;
		n_left   = left_q;
		n_width  = width_q;
		n_acc    = acc_q;
		n_a      = a_q;
		n_b      = b_q;
		n_found  = found_q;
		fin      = 1'b0;
		fin_val  = 16'h0000;
		op_width = 3'd0;
		pos      = width_q - left_q;
		case (phase_q)
			PH_SCAN: begin
				if (stp.data == PACKAGE_OP && name_hit) n_phase = PH_LEAD;
			end
			PH_LEAD: begin
				n_skip  = stp.data[7:6];
				n_phase = (stp.data[7:6] != 2'd0) ? PH_SKIP : PH_COUNT;
			end
			PH_SKIP: begin
				n_skip = skip_q - 2'd1;
				if (skip_q == 2'd1) n_phase = PH_COUNT;
			end
			PH_COUNT: begin
				n_count = stp.data;
				n_found = 1'b1;
				n_idx   = 1'b0;
				n_phase = (stp.data != 8'h00) ? PH_INT_OP : PH_DONE;
			end
			PH_INT_OP: begin
				case (stp.data)
					ZERO_OP:  fin = 1'b1;
					ONE_OP:   begin fin = 1'b1; fin_val = 16'h0001; end
					ONES_OP:  begin fin = 1'b1; fin_val = 16'h00FF; end
					BYTE_OP:  op_width = 3'd1;
					WORD_OP:  op_width = 3'd2;
					DWORD_OP: op_width = 3'd4;
					default:  fin = 1'b1;
				endcase
				if (!fin) begin
					n_width = op_width;
					n_left  = op_width;
					n_acc   = 16'h0000;
					n_phase = PH_INT_DATA;
				end
			end
			PH_INT_DATA: begin
				// little-endian, only the low word is kept
				if (pos == 3'd0) n_acc = {8'h00, stp.data};
				else if (pos == 3'd1) n_acc = acc_q | {stp.data, 8'h00};
				n_left = left_q - 3'd1;
				if (left_q == 3'd1) begin
					fin     = 1'b1;
					fin_val = n_acc;
				end
			end
			default: ;
		endcase
		if (fin) begin
			if (!idx_q) begin
				n_a = fin_val;
				if (count_q >= 8'd2) begin
					n_idx   = 1'b1;
					n_phase = PH_INT_OP;
				end else begin
					n_phase = PH_DONE;
				end
			end else begin
				n_b     = fin_val;
				n_phase = PH_DONE;
			end
		end
		res.found        = n_found;
		res.sleep_type_a = n_a;
		res.sleep_type_b = n_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			skip_q  <= 2'd0;
			count_q <= 8'h00;
			idx_q   <= 1'b0;
			left_q  <= 3'd0;
			width_q <= 3'd0;
			acc_q   <= 16'h0000;
			a_q     <= 16'h0000;
			b_q     <= 16'h0000;
			found_q <= 1'b0;
		end else if (stp.step) begin
			if (stp.last) begin
				phase_q <= PH_SCAN;
				skip_q  <= 2'd0;
				count_q <= 8'h00;
				idx_q   <= 1'b0;
				left_q  <= 3'd0;
				width_q <= 3'd0;
				acc_q   <= 16'h0000;
				a_q     <= 16'h0000;
				b_q     <= 16'h0000;
				found_q <= 1'b0;
			end else begin
				phase_q <= n_phase;
				skip_q  <= n_skip;
				count_q <= n_count;
				idx_q   <= n_idx;
				left_q  <= n_left;
				width_q <= n_width;
				acc_q   <= n_acc;
				a_q     <= n_a;
				b_q     <= n_b;
				found_q <= n_found;
			end
		end
	end

endmodule

FILE: tb/s5_package_checker.sv
// checker of the s5 sleep type extractor: predicts one result per table
// and compares the results on the output channel; depends on aml_s5_pkg
`timescale 1ns / 1ps

module s5_package_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  logic                    item_ready,
	input  aml_s5_pkg::aml_s5_in_t  item,
	input  logic                    result_valid,
	input  logic                    result_ready,
	input  aml_s5_pkg::aml_s5_out_t result,
	output int                      mismatch_count,
	output int unsigned             results_owed
);
	import aml_s5_pkg::*;

	logic [7:0]    recent [WIN_DEPTH];
	logic [2:0]    seen;
	aml_s5_phase_t phase;
	logic [1:0]    skip_left;
	logic [7:0]    elem_count;
	logic          int_index;
	logic [2:0]    int_left;
	logic [2:0]    int_width;
	logic [15:0]   int_acc;
	logic [15:0]   first_value;
	logic [15:0]   second_value;
	logic          found_pkg;

	aml_s5_out_t expected_sleep_types [$];

	task automatic clear_parse();
		int k;
		for (k = 0; k < WIN_DEPTH; k++) begin
			recent[k] = 8'h00;
		end
		seen         = '0;
		phase        = PH_SCAN;
		skip_left    = '0;
		elem_count   = '0;
		int_index    = 1'b0;
		int_left     = '0;
		int_width    = '0;
		int_acc      = '0;
		first_value  = '0;
		second_value = '0;
		found_pkg    = 1'b0;
	endtask

	// a finished integer goes to the first or second slot
	task automatic store_integer(input logic [15:0] v);
		if (int_index == 1'b0) begin
			first_value = v;
			if (elem_count >= 8'd2) begin
				int_index = 1'b1;
				phase     = PH_INT_OP;
			end else begin
				phase = PH_DONE;
			end
		end else begin
			second_value = v;
			phase        = PH_DONE;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic       name_seen;
		logic       plain;
		logic       rooted;
		logic [2:0] pos;
		int         k;
		name_seen = recent[3] == UNDER_CHAR && recent[2] == S_CHAR &&
			recent[1] == FIVE_CHAR && recent[0] == UNDER_CHAR && seen >= 3'd4;
		plain  = seen >= 3'd5 && recent[4] == NAME_OP;
		rooted = seen >= 3'd6 && recent[5] == NAME_OP && recent[4] == ROOT_CHAR;
		case (phase)
			PH_SCAN: begin
				if (b == PACKAGE_OP && name_seen && (plain || rooted))
					phase = PH_LEAD;
			end
			PH_LEAD: begin
				skip_left = b[7:6];
				phase = (skip_left != 2'd0) ? PH_SKIP : PH_COUNT;
			end
			PH_SKIP: begin
				skip_left = skip_left - 2'd1;
				if (skip_left == 2'd0)
					phase = PH_COUNT;
			end
			PH_COUNT: begin
				elem_count = b;
				found_pkg  = 1'b1;
				int_index  = 1'b0;
				phase = (b >= 8'd1) ? PH_INT_OP : PH_DONE;
			end
			PH_INT_OP: begin
				case (b)
					ZERO_OP: store_integer(16'h0000);
					ONE_OP:  store_integer(16'h0001);
					ONES_OP: store_integer(16'h00FF);
					BYTE_OP, WORD_OP, DWORD_OP: begin
						int_width = (b == BYTE_OP) ? 3'd1 : (b == WORD_OP) ? 3'd2 : 3'd4;
						int_left  = int_width;
						int_acc   = '0;
						phase     = PH_INT_DATA;
					end
					default: store_integer(16'h0000);
				endcase
			end
			PH_INT_DATA: begin
				pos = int_width - int_left;
				if (pos == 3'd0)
					int_acc = {8'h00, b};
				else if (pos == 3'd1)
					int_acc[15:8] = b;
				int_left = int_left - 3'd1;
				if (int_left == 3'd0)
					store_integer(int_acc);
			end
			default: ;
		endcase

		for (k = WIN_DEPTH - 1; k > 0; k--) begin
			recent[k] = recent[k - 1];
		end
		recent[0] = b;
		if (seen < 3'd6)
			seen = seen + 3'd1;

		if (last) begin
			expected_sleep_types.push_back('{found: found_pkg, sleep_type_a: first_value,
				sleep_type_b: second_value});
			clear_parse();
		end
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("%0t checker: %s got %0h expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		aml_s5_out_t want;
		if (!arst_n) begin
			clear_parse();
			expected_sleep_types.delete();
			mismatch_count = 0;
		end else begin
			if (item_valid && item_ready)
				parse_byte(item.data_byte, item.is_last);
			if (result_valid && result_ready) begin
				if (expected_sleep_types.size() == 0) begin
					report_mismatch("result with no table end behind it", result.found, 0);
				end else begin
					want = expected_sleep_types.pop_front();
					if (result.found !== want.found)
						report_mismatch("found", result.found, want.found);
					if (result.sleep_type_a !== want.sleep_type_a)
						report_mismatch("sleep_type_a", result.sleep_type_a, want.sleep_type_a);
					if (result.sleep_type_b !== want.sleep_type_b)
						report_mismatch("sleep_type_b", result.sleep_type_b, want.sleep_type_b);
				end
			end
		end
		results_owed = expected_sleep_types.size();
	end

endmodule

FILE: tb/tb_top.sv
// top of the s5 sleep type extractor testbench: clock, reset, table stimulus, verdict
// depends on aml_s5_pkg, aml_s5_sleep_type_extractor and s5_package_checker
`timescale 1ns / 1ps

module tb_top;
	import aml_s5_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int BYTE_TARGET  = 900;
	localparam int TABLE_TARGET = 48;
	localparam int DRAIN_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	aml_s5_in_t  item;
	logic        result_valid;
	logic        result_ready;
	aml_s5_out_t result;

	int          mismatch_count;
	int unsigned results_owed;

	int cycle_count = 0;
	int burst_left  = 0;
	int bytes_sent  = 0;
	int tables_sent = 0;
	bit hold_request = 1'b0;

	// bytes of the table body being built, last one gets is_last
	logic [7:0] body_bytes [$];

	aml_s5_sleep_type_extractor u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	s5_package_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.item           (item),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result         (result),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: cycles through always-ready, coin-flip and sparse stretches;
	// on request it holds off for a long stretch so the block backs up
	initial begin
		int rx_cycle;
		int k;
		rx_cycle = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (hold_request) begin
				result_ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) begin
					@(posedge clk);
				end
				hold_request = 1'b0;
				result_ready <= 1'b1;
			end else if (rx_cycle % 150 < 40) begin
				result_ready <= 1'b1;
			end else if (rx_cycle % 150 < 100) begin
				result_ready <= ($urandom_range(0, 1) == 1);
			end else begin
				result_ready <= (rx_cycle % 5 == 0);
			end
		end
	end

	// bytes that tend to build or spoil a name, mixed with plain random ones
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 9))
			0: return NAME_OP;
			1: return UNDER_CHAR;
			2: return PACKAGE_OP;
			3: return S_CHAR;
			4: return FIVE_CHAR;
			5: return ROOT_CHAR;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one request: sender runs in bursts, random gaps between bursts,
	// now and then a long burst with no gaps at all
	task automatic send_byte(input logic [7:0] b, input logic last);
		int   gap;
		logic took;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		item_valid <= 1'b1;
		item       <= '{data_byte: b, is_last: last};
		// ready is sampled away from the edge, accepted at the next rising edge
		do begin
			@(negedge clk);
			took = item_ready;
			@(posedge clk);
		end while (!took);
		burst_left--;
	endtask

	task automatic send_body();
		int i;
		for (i = 0; i < body_bytes.size(); i++) begin
			send_byte(body_bytes[i], i == body_bytes.size() - 1);
		end
		bytes_sent += body_bytes.size();
		tables_sent++;
	endtask

	// sender goes quiet until every table end has produced its result
	task automatic wait_for_results();
		item_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (results_owed != 0);
		@(posedge clk);
	endtask

	// a name, a package op and a package body with random content;
	// a spoiled header has one of its bytes replaced at random
	task automatic append_package(input bit spoiled);
		int         start;
		int         i;
		int         w;
		logic [7:0] lead;
		logic [7:0] op;
		start = body_bytes.size();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: body_bytes.push_back(NAME_OP);
			5, 6, 7, 8: begin
				body_bytes.push_back(NAME_OP);
				body_bytes.push_back(ROOT_CHAR);
			end
			default: ; // bare name, no name op in front
		endcase
		body_bytes.push_back(UNDER_CHAR);
		body_bytes.push_back(S_CHAR);
		body_bytes.push_back(FIVE_CHAR);
		body_bytes.push_back(UNDER_CHAR);
		body_bytes.push_back(PACKAGE_OP);
		if (spoiled)
			body_bytes[$urandom_range(start, body_bytes.size() - 1)] = noise_byte();

		// package length: lead bits 7:6 give the number of extra length bytes
		lead = 8'($urandom_range(0, 255));
		body_bytes.push_back(lead);
		repeat (lead[7:6]) body_bytes.push_back(8'($urandom_range(0, 255)));

		// element count, mostly small, sometimes anything
		body_bytes.push_back(($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
			: 8'($urandom_range(0, 255)));

		for (i = 0; i < 2; i++) begin
			case ($urandom_range(0, 6))
				0: op = ZERO_OP;
				1: op = ONE_OP;
				2: op = ONES_OP;
				3: op = BYTE_OP;
				4: op = WORD_OP;
				5: op = DWORD_OP;
				default: op = 8'($urandom_range(0, 255));
			endcase
			body_bytes.push_back(op);
			w = (op == BYTE_OP) ? 1 : (op == WORD_OP) ? 2 : (op == DWORD_OP) ? 4 : 0;
			repeat (w) body_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// random table: mostly noise, package, trailing bytes; some pure noise,
	// some cut short anywhere, some with a second package after the first
	task automatic build_random_body();
		int kind;
		int n;
		int cut;
		body_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			n = $urandom_range(1, 30);
			repeat (n) body_bytes.push_back(noise_byte());
		end else begin
			n = $urandom_range(0, 6);
			repeat (n) body_bytes.push_back(noise_byte());
			append_package(kind < 27);
			if ($urandom_range(0, 9) == 0)
				append_package(1'b0);
			n = $urandom_range(0, 4);
			repeat (n) body_bytes.push_back(noise_byte());
			if ($urandom_range(0, 4) == 0) begin
				cut = $urandom_range(1, body_bytes.size());
				while (body_bytes.size() > cut) begin
					void'(body_bytes.pop_back());
				end
			end
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table of a single byte, still produces a result
		body_bytes = '{8'h00};
		send_body();
		// plain name, two elements: a dword cut to 16 bits, then the ones op
		body_bytes = '{NAME_OP, UNDER_CHAR, S_CHAR, FIVE_CHAR, UNDER_CHAR, PACKAGE_OP,
			8'h00, 8'h02, DWORD_OP, 8'h11, 8'h22, 8'h33, 8'h44, ONES_OP};
		send_body();
		// name not followed by a package op is ignored
		body_bytes = '{NAME_OP, UNDER_CHAR, S_CHAR, FIVE_CHAR, UNDER_CHAR, 8'h13, 8'hFF};
		send_body();
		wait_for_results();

		// long receiver hold-off while one-byte tables pile up behind it
		@(negedge clk);
		hold_request = 1'b1;
		@(posedge clk);
		repeat (8) begin
			body_bytes = '{noise_byte()};
			send_body();
		end

		while (bytes_sent < BYTE_TARGET || tables_sent < TABLE_TARGET) begin
			build_random_body();
			send_body();
			// one full pause once half the target number of tables has been sent
			if (tables_sent == TABLE_TARGET / 2)
				wait_for_results();
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
